FILE: src/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Types and fixed widths shared by the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int COMP_W  = 16; // width of one quaternion component
	localparam int ENT_W   = 16; // width of one matrix entry
	localparam int ENTRIES = 9;  // entries of the 3x3 matrix
	localparam int PROD_W  = 32; // signed 16x16 product
	localparam int N_W     = 33; // sum of four squares, up to 2^32
	localparam int NUM_W   = 34; // signed numerator, up to 2^32 in magnitude
	localparam int MAG_W   = 33; // numerator magnitude

	typedef struct packed {
		logic signed [COMP_W-1:0] quat_x;
		logic signed [COMP_W-1:0] quat_y;
		logic signed [COMP_W-1:0] quat_z;
		logic signed [COMP_W-1:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] m00;
		logic signed [ENT_W-1:0] m01;
		logic signed [ENT_W-1:0] m02;
		logic signed [ENT_W-1:0] m10;
		logic signed [ENT_W-1:0] m11;
		logic signed [ENT_W-1:0] m12;
		logic signed [ENT_W-1:0] m20;
		logic signed [ENT_W-1:0] m21;
		logic signed [ENT_W-1:0] m22;
		logic                    zero_norm;
	} rot_t;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [NUM_W-1:0]  num_t;

endpackage

FILE: src/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Quaternion (x, y, z, w) to the nine entries of its 3x3 rotation matrix,
// divided by the norm x^2+y^2+z^2+w^2, signed fixed point, rounded to nearest.
//
//   channel   ports               direction  handshake
//   command   start, busy, quat   in         taken when start && !busy
//   result    done, rot           out        done high for one cycle
//
// One item enters per cycle; busy is always low. The pipeline has three front
// stages (products, norm and numerators, dividend), FRAC_BITS + 1 restoring
// division steps, one quotient bit per stage across all nine lanes, and one
// output register. The receiver cannot stall, so no stage ever holds. Reset
// clears only the valid bits traveling with the data.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
	parameter int FRAC_BITS = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qrm_pkg::quat_t quat,
	output logic           done,
	output qrm_pkg::rot_t  rot
);

	localparam int DW    = qrm_pkg::MAG_W + FRAC_BITS + 1;
	localparam int STEPS = FRAC_BITS + 1;

	// division chain, index k is the input of step k
	logic                    valid_c [STEPS+1];
	logic [qrm_pkg::N_W-1:0] norm_c  [STEPS+1];
	logic                    zero_c  [STEPS+1];
	logic                    neg_c   [STEPS+1][qrm_pkg::ENTRIES];
	logic [DW-1:0]           rem_c   [STEPS+1][qrm_pkg::ENTRIES];
	logic [FRAC_BITS:0]      quo_c   [STEPS+1][qrm_pkg::ENTRIES];

	// no backpressure anywhere: accept every start
	assign busy = 1'b0;

	qrm_prod #(
		.FRAC_BITS(FRAC_BITS)
	) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.quat     (quat),
		.valid    (valid_c[0]),
		.norm     (norm_c[0]),
		.zero     (zero_c[0]),
		.neg      (neg_c[0]),
		.rem      (rem_c[0])
	);

	// quotient starts empty; bits shift in from the top step down
	always_comb begin
		for (int i = 0; i < qrm_pkg::ENTRIES; i++) begin
			quo_c[0][i] = '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		qrm_div_step #(
			.FRAC_BITS (FRAC_BITS),
			.SHIFT     (FRAC_BITS - k)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_c[k]),
			.norm_i  (norm_c[k]),
			.zero_i  (zero_c[k]),
			.neg_i   (neg_c[k]),
			.rem_i   (rem_c[k]),
			.quo_i   (quo_c[k]),
			.valid_o (valid_c[k+1]),
			.norm_o  (norm_c[k+1]),
			.zero_o  (zero_c[k+1]),
			.neg_o   (neg_c[k+1]),
			.rem_o   (rem_c[k+1]),
			.quo_o   (quo_c[k+1])
		);
	end

	// final remainder and norm are dropped; the quotient is the magnitude
	qrm_out #(
		.FRAC_BITS(FRAC_BITS)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_c[STEPS]),
		.zero   (zero_c[STEPS]),
		.neg    (neg_c[STEPS]),
		.quo    (quo_c[STEPS]),
		.done   (done),
		.rot    (rot)
	);

endmodule

FILE: src/qrm_prod.sv
// ----------------------------------------------------------------------------
// qrm_prod
// Front stages: products, norm and numerators, then magnitude and dividend.
// ----------------------------------------------------------------------------
module qrm_prod #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  qrm_pkg::quat_t      quat,
	output logic                valid,
	output logic [qrm_pkg::N_W-1:0] norm,
	output logic                zero,
	output logic                neg [qrm_pkg::ENTRIES],
	output logic [qrm_pkg::MAG_W+FRAC_BITS:0] rem [qrm_pkg::ENTRIES]
);

	localparam int DW = qrm_pkg::MAG_W + FRAC_BITS + 1;

	logic valid_s1, valid_s2, valid_s3;
	qrm_pkg::prod_t xx_s1, yy_s1, zz_s1, ww_s1;
	qrm_pkg::prod_t xy_s1, zw_s1, xz_s1, yw_s1, yz_s1, xw_s1;
	logic [qrm_pkg::N_W-1:0] n_s2, n_s3;
	logic zero_s2, zero_s3;
	qrm_pkg::num_t num_s2 [qrm_pkg::ENTRIES];
	logic neg_s3 [qrm_pkg::ENTRIES];
	logic [DW-1:0] rem_s3 [qrm_pkg::ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: ten products
	always_ff @(posedge clk) begin
		xx_s1 <= $signed(quat.quat_x) * $signed(quat.quat_x);
		yy_s1 <= $signed(quat.quat_y) * $signed(quat.quat_y);
		zz_s1 <= $signed(quat.quat_z) * $signed(quat.quat_z);
		ww_s1 <= $signed(quat.quat_w) * $signed(quat.quat_w);
		xy_s1 <= $signed(quat.quat_x) * $signed(quat.quat_y);
		zw_s1 <= $signed(quat.quat_z) * $signed(quat.quat_w);
		xz_s1 <= $signed(quat.quat_x) * $signed(quat.quat_z);
		yw_s1 <= $signed(quat.quat_y) * $signed(quat.quat_w);
		yz_s1 <= $signed(quat.quat_y) * $signed(quat.quat_z);
		xw_s1 <= $signed(quat.quat_x) * $signed(quat.quat_w);
	end

	// stage 2: norm and numerators
	always_ff @(posedge clk) begin
		n_s2 <= qrm_pkg::N_W'(xx_s1) + qrm_pkg::N_W'(yy_s1)
			+ qrm_pkg::N_W'(zz_s1) + qrm_pkg::N_W'(ww_s1);
		zero_s2 <= ((xx_s1 | yy_s1 | zz_s1 | ww_s1) == '0);
		num_s2[0] <= qrm_pkg::NUM_W'(xx_s1) - qrm_pkg::NUM_W'(yy_s1)
			- qrm_pkg::NUM_W'(zz_s1) + qrm_pkg::NUM_W'(ww_s1);
		num_s2[1] <= (qrm_pkg::NUM_W'(xy_s1) + qrm_pkg::NUM_W'(zw_s1)) <<< 1;
		num_s2[2] <= (qrm_pkg::NUM_W'(xz_s1) - qrm_pkg::NUM_W'(yw_s1)) <<< 1;
		num_s2[3] <= (qrm_pkg::NUM_W'(xy_s1) - qrm_pkg::NUM_W'(zw_s1)) <<< 1;
		num_s2[4] <= qrm_pkg::NUM_W'(yy_s1) - qrm_pkg::NUM_W'(xx_s1)
			- qrm_pkg::NUM_W'(zz_s1) + qrm_pkg::NUM_W'(ww_s1);
		num_s2[5] <= (qrm_pkg::NUM_W'(yz_s1) + qrm_pkg::NUM_W'(xw_s1)) <<< 1;
		num_s2[6] <= (qrm_pkg::NUM_W'(xz_s1) + qrm_pkg::NUM_W'(yw_s1)) <<< 1;
		num_s2[7] <= (qrm_pkg::NUM_W'(yz_s1) - qrm_pkg::NUM_W'(xw_s1)) <<< 1;
		num_s2[8] <= qrm_pkg::NUM_W'(zz_s1) - qrm_pkg::NUM_W'(xx_s1)
			- qrm_pkg::NUM_W'(yy_s1) + qrm_pkg::NUM_W'(ww_s1);
	end

	// stage 3: split sign, form rounded dividend
	always_ff @(posedge clk) begin
		n_s3    <= n_s2;
		zero_s3 <= zero_s2;
		for (int i = 0; i < qrm_pkg::ENTRIES; i++) begin
			neg_s3[i] <= num_s2[i][qrm_pkg::NUM_W-1];
			rem_s3[i] <= (DW'(num_s2[i][qrm_pkg::NUM_W-1] ?
				qrm_pkg::MAG_W'(-num_s2[i]) : qrm_pkg::MAG_W'(num_s2[i])) << FRAC_BITS)
				+ DW'(n_s2 >> 1);
		end
	end

	assign valid = valid_s3;
	assign norm  = n_s3;
	assign zero  = zero_s3;
	assign neg   = neg_s3;
	assign rem   = rem_s3;

endmodule

FILE: src/qrm_div_step.sv
// ----------------------------------------------------------------------------
// qrm_div_step
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module qrm_div_step #(
	parameter int FRAC_BITS = 14,
	parameter int SHIFT     = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_i,
	input  logic [qrm_pkg::N_W-1:0]           norm_i,
	input  logic                              zero_i,
	input  logic                              neg_i [qrm_pkg::ENTRIES],
	input  logic [qrm_pkg::MAG_W+FRAC_BITS:0] rem_i [qrm_pkg::ENTRIES],
	input  logic [FRAC_BITS:0]                quo_i [qrm_pkg::ENTRIES],
	output logic                              valid_o,
	output logic [qrm_pkg::N_W-1:0]           norm_o,
	output logic                              zero_o,
	output logic                              neg_o [qrm_pkg::ENTRIES],
	output logic [qrm_pkg::MAG_W+FRAC_BITS:0] rem_o [qrm_pkg::ENTRIES],
	output logic [FRAC_BITS:0]                quo_o [qrm_pkg::ENTRIES]
);

	localparam int DW = qrm_pkg::MAG_W + FRAC_BITS + 1;

	logic [DW-1:0] trial;
	logic valid_s1, zero_s1;
	logic [qrm_pkg::N_W-1:0] n_s1;
	logic neg_s1 [qrm_pkg::ENTRIES];
	logic [DW-1:0] rem_s1 [qrm_pkg::ENTRIES];
	logic [FRAC_BITS:0] quo_s1 [qrm_pkg::ENTRIES];

	assign trial = DW'(norm_i) << SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	// subtract where the shifted divisor fits, shift in the quotient bit
	always_ff @(posedge clk) begin
		n_s1    <= norm_i;
		zero_s1 <= zero_i;
		for (int i = 0; i < qrm_pkg::ENTRIES; i++) begin
			neg_s1[i] <= neg_i[i];
			if (rem_i[i] >= trial) begin
				rem_s1[i] <= rem_i[i] - trial;
				quo_s1[i] <= {quo_i[i][FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_s1[i] <= rem_i[i];
				quo_s1[i] <= {quo_i[i][FRAC_BITS-1:0], 1'b0};
			end
		end
	end

	assign valid_o = valid_s1;
	assign norm_o  = n_s1;
	assign zero_o  = zero_s1;
	assign neg_o   = neg_s1;
	assign rem_o   = rem_s1;
	assign quo_o   = quo_s1;

endmodule

FILE: src/qrm_out.sv
// ----------------------------------------------------------------------------
// qrm_out
// Output stage: clamp to one, apply sign, clamp to 16 bits, zero on zero norm, register result.
// ----------------------------------------------------------------------------
module qrm_out #(
	parameter int FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  logic               zero,
	input  logic               neg [qrm_pkg::ENTRIES],
	input  logic [FRAC_BITS:0] quo [qrm_pkg::ENTRIES],
	output logic               done,
	output qrm_pkg::rot_t      rot
);

	localparam int VW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic signed [VW-1:0] POS_MAX = VW'(32767);
	localparam logic signed [VW-1:0] NEG_MIN = -VW'(32768);

	logic done_q;
	qrm_pkg::rot_t rot_q;
	logic [qrm_pkg::ENT_W-1:0] ent [qrm_pkg::ENTRIES];

	always_comb begin
		logic [FRAC_BITS:0] qc;
		logic signed [VW-1:0] v;
		for (int i = 0; i < qrm_pkg::ENTRIES; i++) begin
			qc = (quo[i] > ONE) ? ONE : quo[i];
			v  = neg[i] ? -$signed(VW'(qc)) : $signed(VW'(qc));
			if (v > POS_MAX) begin
				v = POS_MAX;
			end else if (v < NEG_MIN) begin
				v = NEG_MIN;
			end
			ent[i] = zero ? '0 : v[qrm_pkg::ENT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rot_q.m00       <= ent[0];
		rot_q.m01       <= ent[1];
		rot_q.m02       <= ent[2];
		rot_q.m10       <= ent[3];
		rot_q.m11       <= ent[4];
		rot_q.m12       <= ent[5];
		rot_q.m20       <= ent[6];
		rot_q.m21       <= ent[7];
		rot_q.m22       <= ent[8];
		rot_q.zero_norm <= zero;
	end

	assign done = done_q;
	assign rot  = rot_q;

endmodule

FILE: tb/sv/quaternion_to_rotation_matrix_checker.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_checker
// Watches the command and result channels of the block, predicts the rotation
// matrix of each accepted quaternion and compares it with the next result.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_checker #(
	parameter int FRAC_BITS = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  qrm_pkg::quat_t quat,
	input  logic           done,
	input  qrm_pkg::rot_t  rot,
	output int             errors,
	output int             pending
);

	qrm_pkg::rot_t matrix_q[$];

	function automatic logic signed [qrm_pkg::ENT_W-1:0] scale_entry(longint num, longint n);
		longint mag;
		longint q;
		longint one;
		longint v;
		mag = (num < 0) ? -num : num;
		one = longint'(1) << FRAC_BITS;
		q = ((mag << FRAC_BITS) + (n >> 1)) / n;
		if (q > one)
			q = one;
		v = (num < 0) ? -q : q;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[qrm_pkg::ENT_W-1:0];
	endfunction

	function automatic qrm_pkg::rot_t rotation_of(qrm_pkg::quat_t qt);
		longint x, y, z, w, xx, yy, zz, ww, n;
		qrm_pkg::rot_t r;
		x = qt.quat_x; y = qt.quat_y; z = qt.quat_z; w = qt.quat_w;
		xx = x * x; yy = y * y; zz = z * z; ww = w * w;
		n = xx + yy + zz + ww;
		r = '0;
		if (n == 0) begin
			r.zero_norm = 1'b1;
			return r;
		end
		r.m00 = scale_entry(xx - yy - zz + ww, n);
		r.m01 = scale_entry(2 * (x * y + z * w), n);
		r.m02 = scale_entry(2 * (x * z - y * w), n);
		r.m10 = scale_entry(2 * (x * y - z * w), n);
		r.m11 = scale_entry(-xx + yy - zz + ww, n);
		r.m12 = scale_entry(2 * (y * z + x * w), n);
		r.m20 = scale_entry(2 * (x * z + y * w), n);
		r.m21 = scale_entry(2 * (y * z - x * w), n);
		r.m22 = scale_entry(-xx - yy + zz + ww, n);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		qrm_pkg::rot_t want;
		if (arst_n) begin
			if (start && !busy)
				matrix_q.push_back(rotation_of(quat));
			if (done) begin
				if (matrix_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = matrix_q.pop_front();
					if (rot.m00 !== want.m00) report_mismatch("m00", rot.m00, want.m00);
					if (rot.m01 !== want.m01) report_mismatch("m01", rot.m01, want.m01);
					if (rot.m02 !== want.m02) report_mismatch("m02", rot.m02, want.m02);
					if (rot.m10 !== want.m10) report_mismatch("m10", rot.m10, want.m10);
					if (rot.m11 !== want.m11) report_mismatch("m11", rot.m11, want.m11);
					if (rot.m12 !== want.m12) report_mismatch("m12", rot.m12, want.m12);
					if (rot.m20 !== want.m20) report_mismatch("m20", rot.m20, want.m20);
					if (rot.m21 !== want.m21) report_mismatch("m21", rot.m21, want.m21);
					if (rot.m22 !== want.m22) report_mismatch("m22", rot.m22, want.m22);
					if (rot.zero_norm !== want.zero_norm)
						report_mismatch("zero_norm", rot.zero_norm, want.zero_norm);
				end
			end
			pending = matrix_q.size();
		end
	end

endmodule

FILE: tb/sv/quaternion_to_rotation_matrix_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Drives directed and random quaternions into the block with random gaps and
// lets the checker compare every matrix against its own prediction.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;

	localparam int FRAC_BITS = 14;
	localparam int LATENCY   = FRAC_BITS + 5;
	localparam int LIMIT     = 200000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	qrm_pkg::quat_t quat;
	logic           done;
	qrm_pkg::rot_t  rot;
	int             errors;
	int             pending;
	int             cycles;
	int             idle_pct;

	quaternion_to_rotation_matrix #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat(quat), .done(done), .rot(rot)
	);

	quaternion_to_rotation_matrix_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .quat(quat),
		.done(done), .rot(rot), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stop a hung run with a verdict of its own.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Pick one component: mostly full range, sometimes an extreme or a tiny value
	// so that small norms and rounding ties get exercised.
	function automatic logic signed [qrm_pkg::COMP_W-1:0] pick_comp();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 16'(int'($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one item, hold it until accepted, then drop start or keep
	// streaming depending on the idle percentage.
	task automatic send_item(qrm_pkg::quat_t q);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		quat  <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic qrm_pkg::quat_t mk(int x, int y, int z, int w);
		qrm_pkg::quat_t q;
		q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z); q.quat_w = 16'(w);
		return q;
	endfunction

	initial begin
		qrm_pkg::quat_t q;
		start    = 1'b0;
		quat     = '0;
		arst_n   = 1'b0;
		idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero quaternion, identity, axis turns, extremes, ties.
		send_item(mk(0, 0, 0, 0));
		send_item(mk(0, 0, 0, 1));
		send_item(mk(0, 0, 0, -32768));
		send_item(mk(32767, 0, 0, 0));
		send_item(mk(0, -32768, 0, 0));
		send_item(mk(0, 0, 32767, 0));
		send_item(mk(1, 1, 1, 1));
		send_item(mk(-1, 1, -1, 1));
		send_item(mk(32767, 32767, 32767, 32767));
		send_item(mk(-32768, -32768, -32768, -32768));
		send_item(mk(-32768, 32767, -32768, 32767));
		send_item(mk(1, 0, 0, 1));
		send_item(mk(1, 2, 3, 4));
		send_item(mk(3, 0, 0, 0));
		send_item(mk(1, 1, 0, 0));
		send_item(mk(0, 0, 0, 0));
		send_item(mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
		send_item(mk(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));

		// Random phases: sender gaps at 38 percent, then 78, then none.
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 38 : (ph == 1) ? 78 : 0;
			for (int i = 0; i < 600; i++) begin
				q.quat_x = pick_comp();
				q.quat_y = pick_comp();
				q.quat_z = pick_comp();
				q.quat_w = pick_comp();
				if ($urandom_range(0, 99) == 0)
					q = '0;
				send_item(q);
			end
		end
		start <= 1'b0;

		// Drain, then give the pipeline time to show stray results.
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
